[sv/bps_pkg.sv]
`default_nettype none
package bps_pkg;
   // Default coordinate width (Q16.16) and limit on steps per segment
   localparam int COORD_WIDTH_DEF = 32;
   localparam int MAX_SAMPLES_DEF = 63;

   // Steps-per-segment register
   localparam int SPS_WIDTH = 6;
   localparam logic [SPS_WIDTH-1:0] SPS_RESET = 6'd16;
endpackage
`default_nettype wire

[sv/bps_ifs.sv]
`default_nettype none
// Waypoint channel
interface bps_req_if #(parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic                          new_path;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   modport source (output valid, new_path, point_x, point_y, input ready);
   modport sink (input valid, new_path, point_x, point_y, output ready);
endinterface

// Sample channel
interface bps_rsp_if #(parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] sample_x;
   logic signed [COORD_WIDTH-1:0] sample_y;
   logic                          segment_end;
   modport source (output valid, sample_x, sample_y, segment_end, input ready);
   modport sink (input valid, sample_x, sample_y, segment_end, output ready);
endinterface

// Register write channel
interface bps_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bps_pkg::SPS_WIDTH-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[sv/bezier_path_smoother.sv]
`default_nettype none
// The first waypoint of a path is taken and gives no sample.
// A closing waypoint first divides for the control points, then forms the segment
// divisor, then computes N+1 samples, each by weights, multiply-accumulate and division,
// using the one shared multiplier and the one-bit-per-cycle restoring divider.
// Throughput: one waypoint at a time; ready is low while a segment is sampled.
// Reset: synchronous, active high; clears the path state, the output and N to 16.
module bezier_path_smoother #(
   parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEF,
   parameter int MAX_SAMPLES = bps_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bps_req_if.sink     req_if,
   bps_rsp_if.source   rsp_if,
   bps_csr_if.sink     csr_if
);
   import bps_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int SW = $clog2(MAX_SAMPLES + 1);
   localparam int DW = 3 * SW;
   localparam int NW = DW + W + 1;
   localparam int PW = W + DW + 2;
   localparam int AW = NW + 1;
   localparam int QW = W + 1;
   localparam int CW = $clog2(QW + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CDIV = 4'd1;
   localparam logic [3:0] ST_DN1  = 4'd2;
   localparam logic [3:0] ST_DN2  = 4'd3;
   localparam logic [3:0] ST_WGT  = 4'd4;
   localparam logic [3:0] ST_MAC  = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_EMIT = 4'd7;

   // Saturate a wide signed value to the coordinate range
   function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
      logic signed [W-1:0] r;
      if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111) begin
         r = v[W-1:0];
      end else if (v[W+1]) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, {(W-1){1'b1}}};
      end
      return r;
   endfunction

   // Biased numerator for round(a + 2b) / 3
   function automatic logic [NW-1:0] div3_num(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
      logic signed [NW-1:0] sa;
      logic signed [NW-1:0] sb;
      sa = NW'(a);
      sb = NW'(b);
      return NW'(sa + (sb <<< 1) + NW'(1) + (NW'(3) << W));
   endfunction

   // Configuration register
   logic [SPS_WIDTH-1:0] sps_ff;
   assign csr_if.ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff <= SPS_RESET;
      end else if (csr_if.valid) begin
         sps_ff <= csr_if.data;
      end
   end

   logic [SW-1:0] n_eff;
   always_comb begin
      if (sps_ff == '0) begin
         n_eff = SW'(1);
      end else if (sps_ff > SPS_WIDTH'(MAX_SAMPLES)) begin
         n_eff = SW'(MAX_SAMPLES);
      end else begin
         n_eff = SW'(sps_ff);
      end
   end

   // Registers
   logic [3:0]              state_ff;
   logic [2:0]              step_ff;
   logic                    coord_ff;
   logic [1:0]              seen_ff;
   logic                    first_ff;
   logic signed [W-1:0]     prev_x_ff, prev_y_ff, ctrl_x_ff, ctrl_y_ff;
   logic signed [W-1:0]     px_ff [4];
   logic signed [W-1:0]     py_ff [4];
   logic [SW-1:0]           n_ff, m_ff;
   logic [DW-1:0]           d_ff;
   logic [2*SW-1:0]         kk_ff, mm_ff;
   logic [DW-1:0]           w_ff [4];
   logic signed [AW-1:0]    acc_ff;
   logic [DW-1:0]           div_rem_ff;
   logic [QW-1:0]           div_num_ff;
   logic [DW-1:0]           div_dv_ff;
   logic [CW-1:0]           div_cnt_ff;
   logic signed [W-1:0]     res_x_ff, res_y_ff;
   logic                    out_valid_ff;
   logic signed [W-1:0]     out_x_ff, out_y_ff;
   logic                    out_end_ff;

   logic [SW-1:0] k_val;
   assign k_val = n_ff - m_ff;

   // Shared multiplier
   logic signed [W:0]    mul_a;
   logic [DW-1:0]        mul_b;
   logic signed [PW-1:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DN1: begin
            mul_a = $signed((W+1)'(n_ff));
            mul_b = DW'(n_ff);
         end
         ST_DN2: begin
            mul_a = $signed((W+1)'(kk_ff));
            mul_b = DW'(n_ff);
         end
         ST_WGT: begin
            case (step_ff)
               3'd0: begin
                  mul_a = $signed((W+1)'(k_val));
                  mul_b = DW'(k_val);
               end
               3'd1: begin
                  mul_a = $signed((W+1)'(m_ff));
                  mul_b = DW'(m_ff);
               end
               3'd2: begin
                  mul_a = $signed((W+1)'(kk_ff));
                  mul_b = DW'(k_val);
               end
               3'd3: begin
                  mul_a = $signed((W+1)'(kk_ff));
                  mul_b = DW'(m_ff);
               end
               3'd4: begin
                  mul_a = $signed((W+1)'(mm_ff));
                  mul_b = DW'(k_val);
               end
               default: begin
                  mul_a = $signed((W+1)'(mm_ff));
                  mul_b = DW'(m_ff);
               end
            endcase
         end
         ST_MAC: begin
            mul_a = coord_ff ? (W+1)'(py_ff[step_ff[1:0]]) : (W+1)'(px_ff[step_ff[1:0]]);
            mul_b = w_ff[step_ff[1:0]];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = PW'(mul_a * $signed({1'b0, mul_b}));

   logic [DW-1:0] mul_lo, mul_x3;
   assign mul_lo = DW'(mul_p);
   assign mul_x3 = mul_lo + {mul_lo[DW-2:0], 1'b0};

   logic signed [AW-1:0] acc_add;
   logic signed [AW-1:0] acc_init;
   assign acc_add  = acc_ff + AW'(mul_p);
   assign acc_init = $signed((AW'(d_ff) << W) + AW'(d_ff >> 1));

   // Restoring divider, one quotient bit per cycle
   logic [DW:0]   div_trial;
   logic          div_qbit;
   logic [DW-1:0] div_rem_nx;
   logic [QW-1:0] div_q;
   logic          div_last;
   logic signed [W-1:0] div_res;
   assign div_trial  = {div_rem_ff, div_num_ff[QW-1]};
   assign div_qbit   = (div_trial >= {1'b0, div_dv_ff});
   assign div_rem_nx = div_qbit ? DW'(div_trial - {1'b0, div_dv_ff}) : DW'(div_trial);
   assign div_q      = {div_num_ff[QW-2:0], div_qbit};
   assign div_last   = (div_cnt_ff == CW'(QW - 1));
   assign div_res    = sat_w((W+2)'($signed({~div_q[QW-1], div_q[QW-2:0]})));

   // Divider load
   logic          div_load;
   logic [NW-1:0] div_load_num;
   logic [DW-1:0] div_load_dv;
   logic [1:0]    next_job;
   assign next_job = step_ff[1:0] + 2'd1;
   logic accept_in, seg_start, emit_go;
   assign accept_in = req_if.valid && req_if.ready;
   assign seg_start = accept_in && !req_if.new_path && (seen_ff != 2'd0);
   assign emit_go   = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_if.ready);

   always_comb begin
      div_load     = 1'b0;
      div_load_num = '0;
      div_load_dv  = DW'(3);
      if (state_ff == ST_IDLE) begin
         div_load     = seg_start;
         div_load_num = div3_num(prev_x_ff, req_if.point_x);
      end else if (state_ff == ST_CDIV) begin
         div_load = div_last && (step_ff[1:0] != 2'd3);
         case (next_job)
            2'd1:    div_load_num = div3_num(py_ff[0], py_ff[3]);
            2'd2:    div_load_num = div3_num(px_ff[3], px_ff[0]);
            default: div_load_num = div3_num(py_ff[3], py_ff[0]);
         endcase
      end else if (state_ff == ST_MAC) begin
         div_load     = (step_ff[1:0] == 2'd3);
         div_load_num = acc_add[NW-1:0];
         div_load_dv  = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         div_rem_ff <= div_load_num[NW-1:QW];
         div_num_ff <= div_load_num[QW-1:0];
         div_dv_ff  <= div_load_dv;
         div_cnt_ff <= '0;
      end else begin
         div_rem_ff <= div_rem_nx;
         div_num_ff <= div_q;
         div_cnt_ff <= div_cnt_ff + CW'(1);
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE) && !reset;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= 2'd0;
         step_ff  <= '0;
         coord_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  if (seg_start) begin
                     state_ff <= ST_CDIV;
                     step_ff  <= '0;
                  end else begin
                     seen_ff <= 2'd1;
                  end
               end
            end
            ST_CDIV: begin
               if (div_last) begin
                  if (step_ff[1:0] == 2'd3) begin
                     state_ff <= ST_DN1;
                  end else begin
                     step_ff <= step_ff + 3'd1;
                  end
               end
            end
            ST_DN1: state_ff <= ST_DN2;
            ST_DN2: begin
               state_ff <= ST_WGT;
               step_ff  <= '0;
            end
            ST_WGT: begin
               if (step_ff == 3'd5) begin
                  state_ff <= ST_MAC;
                  step_ff  <= '0;
                  coord_ff <= 1'b0;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_MAC: begin
               if (step_ff[1:0] == 2'd3) begin
                  state_ff <= ST_DIV;
               end
               step_ff <= step_ff + 3'd1;
            end
            ST_DIV: begin
               if (div_last) begin
                  step_ff <= '0;
                  if (!coord_ff) begin
                     coord_ff <= 1'b1;
                     state_ff <= ST_MAC;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  if (m_ff == n_ff) begin
                     state_ff <= ST_IDLE;
                     seen_ff  <= 2'd2;
                  end else begin
                     state_ff <= ST_WGT;
                     step_ff  <= '0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept_in) begin
               if (seg_start) begin
                  px_ff[0] <= prev_x_ff;
                  py_ff[0] <= prev_y_ff;
                  px_ff[3] <= req_if.point_x;
                  py_ff[3] <= req_if.point_y;
                  px_ff[1] <= sat_w((W+2)'(prev_x_ff) * (W+2)'(2) - (W+2)'(ctrl_x_ff));
                  py_ff[1] <= sat_w((W+2)'(prev_y_ff) * (W+2)'(2) - (W+2)'(ctrl_y_ff));
                  first_ff <= (seen_ff == 2'd1);
                  n_ff     <= n_eff;
               end else begin
                  prev_x_ff <= req_if.point_x;
                  prev_y_ff <= req_if.point_y;
                  ctrl_x_ff <= '0;
                  ctrl_y_ff <= '0;
               end
            end
         end
         ST_CDIV: begin
            if (div_last) begin
               case (step_ff[1:0])
                  2'd0: px_ff[2] <= div_res;
                  2'd1: py_ff[2] <= div_res;
                  2'd2: if (first_ff) px_ff[1] <= div_res;
                  default: if (first_ff) py_ff[1] <= div_res;
               endcase
            end
         end
         ST_DN1: kk_ff <= (2*SW)'(mul_p);
         ST_DN2: begin
            d_ff <= mul_lo;
            m_ff <= '0;
         end
         ST_WGT: begin
            case (step_ff)
               3'd0: kk_ff <= (2*SW)'(mul_p);
               3'd1: mm_ff <= (2*SW)'(mul_p);
               3'd2: w_ff[0] <= mul_lo;
               3'd3: w_ff[1] <= mul_x3;
               3'd4: w_ff[2] <= mul_x3;
               default: begin
                  w_ff[3] <= mul_lo;
                  acc_ff  <= acc_init;
               end
            endcase
         end
         ST_MAC: acc_ff <= acc_add;
         ST_DIV: begin
            if (div_last) begin
               acc_ff <= acc_init;
               if (!coord_ff) begin
                  res_x_ff <= div_res;
               end else begin
                  res_y_ff <= div_res;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               m_ff <= m_ff + SW'(1);
               if (m_ff == n_ff) begin
                  prev_x_ff <= px_ff[3];
                  prev_y_ff <= py_ff[3];
                  ctrl_x_ff <= px_ff[2];
                  ctrl_y_ff <= py_ff[2];
               end
            end
         end
         default: acc_ff <= acc_ff;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (emit_go) begin
         out_x_ff   <= res_x_ff;
         out_y_ff   <= res_y_ff;
         out_end_ff <= (m_ff == n_ff);
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.sample_x    = out_x_ff;
   assign rsp_if.sample_y    = out_y_ff;
   assign rsp_if.segment_end = out_end_ff;

   // Checks
   a_wgt_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && step_ff == 3'd0 && !coord_ff) |->
      ((DW+2)'(w_ff[0]) + (DW+2)'(w_ff[1]) + (DW+2)'(w_ff[2]) + (DW+2)'(w_ff[3])
       == (DW+2)'(d_ff)))
      else $error("Bernstein weights do not sum to the segment divisor");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_CDIV) |-> (div_cnt_ff < CW'(QW)))
      else $error("divider ran past its last quotient bit");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_go && m_ff == n_ff) |=> (state_ff == ST_IDLE && out_end_ff))
      else $error("last sample did not close the segment");
   a_step_m: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WGT) |-> (m_ff <= n_ff))
      else $error("sample index beyond step count");
endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = bps_pkg::COORD_WIDTH_DEF;
   localparam int NMAX = bps_pkg::MAX_SAMPLES_DEF;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic                 new_path;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
   } waypoint_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic                 seg_end;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bps_req_if #(.COORD_WIDTH(CW)) req_if ();
   bps_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();
   bps_csr_if csr_if ();

   bezier_path_smoother #(.COORD_WIDTH(CW), .MAX_SAMPLES(NMAX)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source),
      .csr_if(csr_if.sink)
   );

   always #5 clock = ~clock;

   waypoint_type waypoint_q[$];
   sample_type   sample_exp_q[$];
   int        errors = 0;
   int        waypoints_sent = 0;
   int        samples_seen = 0;
   int        segments_seen = 0;
   int        idle_cycles = 0;
   int        hold_off = 0;
   int        long_stall_left = 0;
   bit        traffic_done = 1'b0;

   // Curve predictor state
   logic [5:0]    steps_reg;
   longint        last_pt_x, last_pt_y, last_ctl_x, last_ctl_y;
   int            path_phase;

   function automatic longint clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint floor_quot(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint third_rounded(longint v);
      return floor_quot(v + 1, 3);
   endfunction

   // Exact rounded Bernstein sum, split into high and low 16-bit halves
   function automatic longint bernstein_point(longint c0, longint c1, longint c2,
                                              longint c3, int m, int n);
      longint pts[4], wt[4], hi_sum, lo_sum, q, r, d, k, hi, lo;
      pts[0] = c0; pts[1] = c1; pts[2] = c2; pts[3] = c3;
      k = n - m;
      d = longint'(n) * n * n;
      wt[0] = k * k * k;
      wt[1] = 3 * m * k * k;
      wt[2] = 3 * longint'(m) * m * k;
      wt[3] = longint'(m) * m * m;
      hi_sum = 0;
      lo_sum = 0;
      for (int i = 0; i < 4; i++) begin
         hi = floor_quot(pts[i], 65536);
         lo = pts[i] - hi * 65536;
         hi_sum += wt[i] * hi;
         lo_sum += wt[i] * lo;
      end
      q = floor_quot(hi_sum, d);
      r = hi_sum - q * d;
      return clamp_coord(q * 65536 + (r * 65536 + lo_sum + d / 2) / d);
   endfunction

   // Append one waypoint to the pending queue
   function automatic void add_waypoint(waypoint_type w);
      waypoint_q.insert(waypoint_q.size(), w);
   endfunction

   task automatic predict_segment(waypoint_type wp);
      longint x3, y3, x1, y1, x2, y2;
      int n;
      sample_type s;
      x3 = wp.px;
      y3 = wp.py;
      if (wp.new_path || path_phase == 0) begin
         last_pt_x = x3; last_pt_y = y3;
         last_ctl_x = 0; last_ctl_y = 0;
         path_phase = 1;
         return;
      end
      if (path_phase == 1) begin
         x1 = third_rounded(2 * last_pt_x + x3);
         y1 = third_rounded(2 * last_pt_y + y3);
      end else begin
         x1 = clamp_coord(2 * last_pt_x - last_ctl_x);
         y1 = clamp_coord(2 * last_pt_y - last_ctl_y);
      end
      x2 = third_rounded(last_pt_x + 2 * x3);
      y2 = third_rounded(last_pt_y + 2 * y3);
      n = steps_reg;
      if (n < 1) n = 1;
      if (n > NMAX) n = NMAX;
      for (int m = 0; m <= n; m++) begin
         s.sx = CW'(bernstein_point(last_pt_x, x1, x2, x3, m, n));
         s.sy = CW'(bernstein_point(last_pt_y, y1, y2, y3, m, n));
         s.seg_end = (m == n);
         sample_exp_q.insert(sample_exp_q.size(), s);
      end
      last_pt_x = x3; last_pt_y = y3;
      last_ctl_x = x2; last_ctl_y = y2;
      path_phase = 2;
   endtask

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Waypoint driver: hold the item until accepted, then idle a random gap
   int send_gap = 0;
   bit gaps_on = 1'b1;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_segment(waypoint_type'{req_if.new_path, req_if.point_x, req_if.point_y});
            waypoints_sent++;
            void'(waypoint_q.pop_front());
            send_gap = gaps_on ? short_or_long_gap() : 0;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (waypoint_q.size() > 0) begin
               req_if.valid    <= 1'b1;
               req_if.new_path <= waypoint_q[0].new_path;
               req_if.point_x  <= waypoint_q[0].px;
               req_if.point_y  <= waypoint_q[0].py;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Sample monitor: random ready, with an occasional long hold-off
   always @(posedge clock) begin
      sample_type exp_s;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            samples_seen++;
            if (rsp_if.segment_end) segments_seen++;
            if (sample_exp_q.size() == 0) begin
               $error("unexpected sample x=%0d y=%0d", rsp_if.sample_x, rsp_if.sample_y);
               errors++;
            end else begin
               exp_s = sample_exp_q.pop_front();
               if (rsp_if.sample_x !== exp_s.sx) begin
                  $error("sample_x expected %0d got %0d", exp_s.sx, rsp_if.sample_x);
                  errors++;
               end
               if (rsp_if.sample_y !== exp_s.sy) begin
                  $error("sample_y expected %0d got %0d", exp_s.sy, rsp_if.sample_y);
                  errors++;
               end
               if (rsp_if.segment_end !== exp_s.seg_end) begin
                  $error("segment_end expected %0b got %0b", exp_s.seg_end,
                         rsp_if.segment_end);
                  errors++;
               end
            end
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (gaps_on) hold_off = short_or_long_gap();
         end
      end
   end

   // Watchdog: count cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready) || traffic_done) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("stalled after %0d waypoints and %0d samples",
                  waypoints_sent, samples_seen);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (waypoint_q.size() > 0 || req_if.valid || sample_exp_q.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_steps(logic [5:0] n);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= n;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      steps_reg = n;
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(CW-1){1'b1}}};
         1: return {1'b1, {(CW-1){1'b0}}};
         2: return $signed($urandom_range(0, 20000)) - 10000;
         default: return $urandom;
      endcase
   endfunction

   function automatic waypoint_type rand_waypoint(bit first);
      waypoint_type w;
      w.new_path = first;
      w.px = rand_coord();
      w.py = rand_coord();
      return w;
   endfunction

   // Paths: a head waypoint then a few closing waypoints, with stray restarts
   task automatic queue_paths(int count);
      int left;
      left = count;
      while (left > 0) begin
         add_waypoint(rand_waypoint(1'b1));
         left--;
         for (int j = $urandom_range(1, 6); j > 0 && left > 0; j--) begin
            add_waypoint(rand_waypoint($urandom_range(0, 15) == 0));
            left--;
         end
      end
   endtask

   logic signed [CW-1:0] cmax, cmin;
   initial begin
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      req_if.valid = 1'b0;
      req_if.new_path = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      steps_reg = bps_pkg::SPS_RESET;
      path_phase = 0;
      last_pt_x = 0; last_pt_y = 0; last_ctl_x = 0; last_ctl_y = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed at reset N: path started without the flag, extremes, reflection
      add_waypoint(waypoint_type'{1'b0, cmax, cmin});
      add_waypoint(waypoint_type'{1'b0, cmin, cmax});
      add_waypoint(waypoint_type'{1'b0, cmax, cmax});
      add_waypoint(waypoint_type'{1'b0, cmin, cmin});
      add_waypoint(waypoint_type'{1'b1, 32'sd0, 32'sd0});
      add_waypoint(waypoint_type'{1'b0, 32'sd1, -32'sd1});
      add_waypoint(waypoint_type'{1'b0, 32'sd65536, -32'sd65536});
      add_waypoint(waypoint_type'{1'b0, -32'sd2, 32'sd2});
      add_waypoint(waypoint_type'{1'b1, 32'sd5, 32'sd7});
      add_waypoint(waypoint_type'{1'b1, cmax, cmin});
      add_waypoint(waypoint_type'{1'b0, cmin, cmax});
      wait_drained();

      // Zero acts as one, then the largest value of 63
      write_steps(6'd0);
      add_waypoint(waypoint_type'{1'b1, 32'sd100, -32'sd100});
      add_waypoint(waypoint_type'{1'b0, cmax, cmin});
      add_waypoint(waypoint_type'{1'b0, -32'sd3, 32'sd3});
      write_steps(6'd63);
      add_waypoint(waypoint_type'{1'b0, cmin, cmax});
      add_waypoint(waypoint_type'{1'b0, cmax, cmin});

      // Fill the block with the receiver held off
      wait_drained();
      gaps_on = 1'b0;
      long_stall_left = 1000;
      queue_paths(6);
      wait_drained();
      gaps_on = 1'b1;

      // Random phases over several step counts
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_steps(6'd1);
            1: write_steps(6'd2);
            2: write_steps(6'($urandom_range(3, 12)));
            3: write_steps(6'd63);
            4: write_steps(6'($urandom_range(0, 63)));
            default: write_steps(6'd5);
         endcase
         queue_paths(ph == 3 ? 20 : 78);
      end
      wait_drained();
      traffic_done = 1'b1;

      $display("covered %0d waypoints, %0d samples in %0d segments",
               waypoints_sent, samples_seen, segments_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
